// File: rtl/core/lfulru_pkg.sv
// Package for the LFU replacement block with LRU tie-break.
// Holds the operation codes and the request and response beat types.
// No dependencies.
`timescale 1ns / 1ps

package lfulru_pkg;

  // operation codes
  localparam logic [1:0] FUNC_INVAL  = 2'd0;
  localparam logic [1:0] FUNC_TOUCH  = 2'd1;
  localparam logic [1:0] FUNC_INSERT = 2'd2;
  localparam logic [1:0] FUNC_QUERY  = 2'd3;

  // request beat
  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  set_index;
    logic [2:0]  way;
    logic [31:0] now;
  } req_t;

  // response beat
  typedef struct packed {
    logic [2:0] victim_way;
    logic       victim_valid;
  } rsp_t;

endpackage

// File: rtl/core/lfulru_store.sv
// Single-port replacement state memory with registered read data.
// One entry per way of every set: {use count, touch time}.
// No package dependency.
`timescale 1ns / 1ps

module lfulru_store #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 48,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port share one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/lfu_lru_tiebreak_replacement.sv
// Update (invalidate, touch, insert): one item at a time, a read-modify-write on the single
// memory port, read in RD and written in WR; the result beat loads in DONE after the write.
// Victim query: one item at a time; the memory reads one way per cycle into
// one shared count/time comparator.
// Reset: synchronous; then a pass clears all NUM_SETS * NUM_WAYS entries, req_stall high.
// Depends on lfulru_pkg and lfulru_store.
`timescale 1ns / 1ps

module lfu_lru_tiebreak_replacement import lfulru_pkg::*; #(
  parameter int NUM_WAYS   = 8,
  parameter int NUM_SETS   = 64,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int DEPTH = NUM_SETS * NUM_WAYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int CNT_W = WAY_W + 1;
  localparam int EW    = COUNT_BITS + TIME_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WR,
    S_QRY,
    S_DONE
  } state_t;

  state_t                state;
  logic [AW-1:0]         clr_addr;
  logic [1:0]            func;
  logic                  op_ok;
  logic [AW-1:0]         base;
  logic [AW-1:0]         idx;
  logic [TIME_BITS-1:0]  now_t;
  logic [CNT_W-1:0]      cnt;
  logic                  pend;
  logic [WAY_W-1:0]      pend_way;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [TIME_BITS-1:0]  best_time;
  logic [WAY_W-1:0]      best_way;

  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [EW-1:0]         mem_wdata;
  logic [EW-1:0]         mem_rdata;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [TIME_BITS-1:0]  rd_time;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic                  better;
  logic                  acc;
  logic                  qry_last;
  logic                  req_set_ok;
  logic                  req_way_ok;
  logic [31:0]           req_base;
  logic [31:0]           victim_wide;

  lfulru_store #(
    .DEPTH (DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign acc       = req_valid && !req_stall;

  // range checks and entry address of the incoming request
  assign req_set_ok = (32'(req.set_index) < 32'(NUM_SETS));
  assign req_way_ok = (32'(req.way) < 32'(NUM_WAYS));
  assign req_base   = 32'(req.set_index) * 32'(NUM_WAYS);

  // fields of the entry just read
  assign rd_cnt  = mem_rdata[TIME_BITS +: COUNT_BITS];
  assign rd_time = mem_rdata[TIME_BITS-1:0];
  assign inc_cnt = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + COUNT_BITS'(1);

  // shared comparator: lowest count, then oldest time, first way wins exact ties
  assign better = (pend_way == '0) || (rd_cnt < best_cnt) ||
                  ((rd_cnt == best_cnt) && (rd_time < best_time));

  assign qry_last = (cnt == CNT_W'(NUM_WAYS));

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = idx;
    mem_wdata = mem_rdata;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_WR: begin
        mem_we = op_ok;
        case (func)
          FUNC_INVAL:  mem_wdata = '0;
          FUNC_TOUCH:  mem_wdata = {inc_cnt, now_t};
          FUNC_INSERT: mem_wdata = {COUNT_BITS'(1), now_t};
          default:     mem_wdata = mem_rdata;
        endcase
      end
      S_QRY: begin
        mem_re   = !qry_last;
        mem_addr = base + AW'(cnt[WAY_W-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign victim_wide = 32'(best_way);

  // sequencer, comparator registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
    end else begin
      // a taken beat clears unless a new one loads in the same cycle
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            func     <= req.func;
            op_ok    <= req_set_ok && req_way_ok;
            base     <= req_base[AW-1:0];
            idx      <= AW'(req_base + 32'(req.way));
            now_t    <= TIME_BITS'(req.now);
            cnt      <= '0;
            pend     <= 1'b0;
            best_way <= '0;
            if (req.func == FUNC_QUERY) begin
              state <= req_set_ok ? S_QRY : S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_QRY: begin
          if (!qry_last) begin
            cnt      <= cnt + CNT_W'(1);
            pend_way <= cnt[WAY_W-1:0];
          end
          pend <= !qry_last;
          if (pend && better) begin
            best_cnt  <= rd_cnt;
            best_time <= rd_time;
            best_way  <= pend_way;
          end
          if (qry_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.victim_valid <= (func == FUNC_QUERY);
            rsp.victim_way   <= (func == FUNC_QUERY) ? victim_wide[2:0] : 3'd0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/lfulru_checker.sv
// Port-level checker for the LFU replacement block, bound to the top level.
// Depends on lfulru_pkg and lfu_lru_tiebreak_replacement.
`timescale 1ns / 1ps

module lfulru_checker import lfulru_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

  // only a query answer carries a nonzero way
  a_way_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.victim_valid |-> rsp.victim_way == 3'd0)
    else $error("non-query response has nonzero way");

  // one item at a time: busy right after an accepted request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous item in flight");

  // clearing pass holds off requests right after reset
  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall && !rsp_valid)
    else $error("block open for requests during clearing pass");

endmodule

bind lfu_lru_tiebreak_replacement lfulru_checker u_lfulru_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
